>>> hdl/afp_pkg.sv
// Shared types, codes and helper functions for the ASCII integer field parser.
`default_nettype none

package afp_pkg;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGNED,
        PH_ZERO,
        PH_DIGITS,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        BASE_DEC,
        BASE_OCT,
        BASE_HEX
    } base_t;

    typedef enum logic [1:0] {
        REG_KIND  = 2'd0,
        REG_WIDTH = 2'd1,
        REG_SIZE  = 2'd2
    } reg_index_t;

    localparam logic [2:0] KIND_SDEC = 3'd0;
    localparam logic [2:0] KIND_AUTO = 3'd1;
    localparam logic [2:0] KIND_UDEC = 3'd2;
    localparam logic [2:0] KIND_OCT  = 3'd3;
    localparam logic [2:0] KIND_HEX  = 3'd4;

    localparam logic [1:0] SIZE_8  = 2'd0;
    localparam logic [1:0] SIZE_16 = 2'd1;
    localparam logic [1:0] SIZE_32 = 2'd2;
    localparam logic [1:0] SIZE_64 = 2'd3;

    localparam logic [63:0] SMAX     = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] UMAX     = 64'hffff_ffff_ffff_ffff;
    localparam logic [63:0] SMIN_PAT = 64'h8000_0000_0000_0000;

    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_7     = 8'h37;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_A_UP  = 8'h41;
    localparam logic [7:0] CH_F_UP  = 8'h46;
    localparam logic [7:0] CH_X_UP  = 8'h58;
    localparam logic [7:0] CH_A_LO  = 8'h61;
    localparam logic [7:0] CH_F_LO  = 8'h66;
    localparam logic [7:0] CH_X_LO  = 8'h78;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] width;
        logic [1:0] size;
    } cfg_t;

    // closed field, before sign handling and truncation
    typedef struct packed {
        logic [63:0] acc;
        logic        neg;
        logic        sat;
        logic        matched;
        logic        is_signed;
        logic [1:0]  size;
        logic        not_consumed;
    } raw_t;

    // {valid, digit}
    function automatic logic [4:0] digit_value(input logic [7:0] c, input base_t b);
        logic [4:0] r;
        r = 5'd0;
        if (b == BASE_OCT) begin
            if (c >= CH_0 && c <= CH_7)
                r = {1'b1, c[3:0]};
        end
        else begin
            if (c >= CH_0 && c <= CH_9)
                r = {1'b1, c[3:0]};
            else if (b == BASE_HEX && ((c >= CH_A_LO && c <= CH_F_LO) ||
                                       (c >= CH_A_UP && c <= CH_F_UP)))
                r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

    function automatic logic [63:0] format_value(input raw_t r);
        logic [63:0] v;
        v = 64'd0;
        if (r.matched) begin
            if (r.sat) begin
                if (r.is_signed)
                    v = r.neg ? SMIN_PAT : SMAX;
                else
                    v = r.neg ? 64'd0 : UMAX;
            end
            else begin
                v = r.neg ? (64'd0 - r.acc) : r.acc;
            end
            case (r.size)
                SIZE_8:  v = v & 64'h0000_0000_0000_00ff;
                SIZE_16: v = v & 64'h0000_0000_0000_ffff;
                SIZE_32: v = v & 64'h0000_0000_ffff_ffff;
                default: v = v;
            endcase
        end
        return v;
    endfunction

endpackage

`default_nettype wire

>>> hdl/ascii_integer_field_parser_top.sv
// Top level of the ASCII integer field parser: input stage, parser, result stage.
//
//   channel   direction  handshake                 payload
//   in        sink       in_valid / in_stall       character, new_field, end_of_text
//   out       source     out_valid / out_stall     value, found, byte_not_consumed
//   cfg       sink       psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One byte per cycle unless a stalled result blocks it: a beat is held in the input
// register, is parsed in one pass and its result (if any) lands in the result register.
// Rate is set by the per-byte multiply-add and overflow compare into the accumulator.
// Reset is asynchronous; config resets to signed decimal, no width limit, 32-bit result.
// in_stall rises only while a held result is stalled and a new beat waits behind it.
`default_nettype none

module ascii_integer_field_parser_top #(
    parameter int MAX_FIELD_WIDTH = 255
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  character,
    input  wire logic        new_field,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      value,
    output logic             found,
    output logic             byte_not_consumed,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [7:0] WIDTH_CAP = (MAX_FIELD_WIDTH >= 255) ? 8'd255
                                                                : 8'(MAX_FIELD_WIDTH);

    afp_pkg::cfg_t cfg;
    afp_pkg::raw_t raw;
    afp_pkg::raw_t out_raw_reg;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg;
    logic       nf_reg;
    logic       eot_reg;
    logic       out_valid_reg, out_valid_next;
    logic       in_accept;
    logic       advance;
    logic       emit;

    afp_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    afp_parse #(
        .WIDTH_CAP (WIDTH_CAP)
    ) u_parse (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .character   (char_reg),
        .new_field   (nf_reg),
        .end_of_text (eot_reg),
        .cfg         (cfg),
        .emit        (emit),
        .raw         (raw)
    );

    // held beat moves on when the result slot is free or draining this cycle
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance && emit)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            char_reg <= character;
            nf_reg   <= new_field;
            eot_reg  <= end_of_text;
        end
        if (advance && emit)
            out_raw_reg <= raw;
    end

    assign out_valid         = out_valid_reg;
    assign value             = afp_pkg::format_value(out_raw_reg);
    assign found             = out_raw_reg.matched;
    assign byte_not_consumed = out_raw_reg.not_consumed;

`ifndef SYNTH
    a_stall_only_behind_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a stalled result");

    a_fail_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (value == 64'd0))
        else $error("failed field with nonzero value");

    a_result_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !(advance && emit)) |=> !out_valid)
        else $error("result beat repeated");

    a_byte_trunc: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_raw_reg.size == afp_pkg::SIZE_8) |-> (value[63:8] == 56'd0))
        else $error("8-bit result not truncated");

    a_new_result_needs_beat: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid && !in_valid_reg) |=> !out_valid)
        else $error("result without an input beat");
`endif

endmodule

`default_nettype wire

>>> hdl/afp_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module afp_regs (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [3:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output afp_pkg::cfg_t     cfg
);

    logic [2:0] kind_reg, kind_next;
    logic [7:0] width_reg, width_next;
    logic [1:0] size_reg, size_next;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_comb
    begin
        kind_next  = kind_reg;
        width_next = width_reg;
        size_next  = size_reg;
        if (wr_en)
        begin
            unique case (afp_pkg::reg_index_t'(paddr[3:2]))
                afp_pkg::REG_KIND:  kind_next  = pwdata[2:0];
                afp_pkg::REG_WIDTH: width_next = pwdata[7:0];
                afp_pkg::REG_SIZE:  size_next  = pwdata[1:0];
                default:            kind_next  = kind_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (afp_pkg::reg_index_t'(paddr[3:2]))
            afp_pkg::REG_KIND:  prdata = {29'd0, kind_reg};
            afp_pkg::REG_WIDTH: prdata = {24'd0, width_reg};
            afp_pkg::REG_SIZE:  prdata = {30'd0, size_reg};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= afp_pkg::KIND_SDEC;
            width_reg <= 8'd0;
            size_reg  <= afp_pkg::SIZE_32;
        end
        else
        begin
            kind_reg  <= kind_next;
            width_reg <= width_next;
            size_reg  <= size_next;
        end
    end

    assign cfg.kind  = kind_reg;
    assign cfg.width = width_reg;
    assign cfg.size  = size_reg;

endmodule

`default_nettype wire

>>> hdl/afp_parse.sv
// Field parser state and the per-byte step logic.
`default_nettype none

module afp_parse #(
    parameter logic [7:0] WIDTH_CAP = 8'd255
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          step,
    input  wire logic [7:0]    character,
    input  wire logic          new_field,
    input  wire logic          end_of_text,
    input  wire afp_pkg::cfg_t cfg,
    output logic               emit,
    output afp_pkg::raw_t      raw
);

    afp_pkg::phase_t phase_reg, phase_next;
    afp_pkg::base_t  base_reg, base_next;
    logic [63:0]     acc_reg, acc_next;
    logic            neg_reg, neg_next;
    logic            sat_reg, sat_next;
    logic            matched_reg, matched_next;
    logic            lim_reg, lim_next;
    logic [7:0]      wl_reg, wl_next;

    logic [2:0]      kind;
    logic [7:0]      width_eff;
    logic            take;
    logic            digit_path;
    logic            close_nc;
    logic [4:0]      dv;
    logic [67:0]     prod;
    logic [68:0]     sum;
    logic [63:0]     max_mag;

    assign kind      = (cfg.kind > afp_pkg::KIND_HEX) ? afp_pkg::KIND_SDEC : cfg.kind;
    assign width_eff = (cfg.width > WIDTH_CAP) ? WIDTH_CAP : cfg.width;
    assign max_mag   = (kind <= afp_pkg::KIND_AUTO) ? afp_pkg::SMAX : afp_pkg::UMAX;

    // next state
    always_comb
    begin
        phase_next   = new_field ? afp_pkg::PH_START : phase_reg;
        base_next    = base_reg;
        acc_next     = acc_reg;
        neg_next     = neg_reg;
        sat_next     = sat_reg;
        matched_next = matched_reg;
        lim_next     = lim_reg;
        wl_next      = wl_reg;
        emit         = 1'b0;
        close_nc     = 1'b0;
        take         = 1'b0;
        digit_path   = 1'b0;
        dv           = 5'd0;
        prod         = 68'd0;
        sum          = 69'd0;

        if (phase_next == afp_pkg::PH_START)
        begin
            acc_next     = 64'd0;
            neg_next     = 1'b0;
            sat_next     = 1'b0;
            matched_next = 1'b0;
            base_next    = afp_pkg::BASE_DEC;
            lim_next     = (width_eff != 8'd0);
            wl_next      = width_eff;
        end

        if (phase_next != afp_pkg::PH_DONE)
        begin
            if (end_of_text)
            begin
                emit = 1'b1;
            end
            else
            begin
                if (phase_next == afp_pkg::PH_START)
                begin
                    if (character == afp_pkg::CH_PLUS || character == afp_pkg::CH_MINUS)
                    begin
                        neg_next = (character == afp_pkg::CH_MINUS);
                        take     = 1'b1;
                    end
                    phase_next = afp_pkg::PH_SIGNED;
                end

                if (!take)
                begin
                    if (phase_next == afp_pkg::PH_SIGNED)
                    begin
                        if (character == afp_pkg::CH_0 && (kind == afp_pkg::KIND_HEX ||
                            (kind == afp_pkg::KIND_AUTO && (!lim_next || wl_next > 8'd1))))
                        begin
                            matched_next = 1'b1;
                            base_next    = (kind == afp_pkg::KIND_HEX) ? afp_pkg::BASE_HEX
                                                                       : afp_pkg::BASE_OCT;
                            phase_next   = afp_pkg::PH_ZERO;
                            take         = 1'b1;
                        end
                        else
                        begin
                            if (kind == afp_pkg::KIND_OCT)
                                base_next = afp_pkg::BASE_OCT;
                            else if (kind == afp_pkg::KIND_HEX)
                                base_next = afp_pkg::BASE_HEX;
                            else
                                base_next = afp_pkg::BASE_DEC;
                            phase_next = afp_pkg::PH_DIGITS;
                            digit_path = 1'b1;
                        end
                    end
                    else if (phase_next == afp_pkg::PH_ZERO)
                    begin
                        phase_next = afp_pkg::PH_DIGITS;
                        if (character == afp_pkg::CH_X_LO || character == afp_pkg::CH_X_UP)
                        begin
                            base_next = afp_pkg::BASE_HEX;
                            take      = 1'b1;
                        end
                        else
                        begin
                            digit_path = 1'b1;
                        end
                    end
                    else
                    begin
                        digit_path = 1'b1;
                    end
                end

                if (digit_path)
                begin
                    dv = afp_pkg::digit_value(character, base_next);
                    if (!dv[4])
                    begin
                        emit     = 1'b1;
                        close_nc = 1'b1;
                    end
                    else
                    begin
                        matched_next = 1'b1;
                        take         = 1'b1;
                        if (!sat_next)
                        begin
                            case (base_next)
                                afp_pkg::BASE_HEX: prod = {acc_next, 4'd0};
                                afp_pkg::BASE_OCT: prod = {1'b0, acc_next, 3'd0};
                                default:           prod = {1'b0, acc_next, 3'd0}
                                                        + {3'd0, acc_next, 1'b0};
                            endcase
                            sum = {1'b0, prod} + {65'd0, dv[3:0]};
                            if (sum > {5'd0, max_mag})
                            begin
                                sat_next = 1'b1;
                                acc_next = max_mag;
                            end
                            else
                            begin
                                acc_next = sum[63:0];
                            end
                        end
                    end
                end

                // byte is part of the field: count it against the width
                if (take && lim_next)
                begin
                    if (wl_next != 8'd0)
                        wl_next = wl_next - 8'd1;
                    if (wl_next == 8'd0)
                        emit = 1'b1;
                end
            end

            if (emit)
                phase_next = afp_pkg::PH_DONE;
        end
    end

    // outputs
    always_comb
    begin
        raw.acc          = acc_next;
        raw.neg          = neg_next;
        raw.sat          = sat_next;
        raw.matched      = matched_next;
        raw.is_signed    = (kind <= afp_pkg::KIND_AUTO);
        raw.size         = cfg.size;
        raw.not_consumed = close_nc;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= afp_pkg::PH_START;
            base_reg    <= afp_pkg::BASE_DEC;
            acc_reg     <= 64'd0;
            neg_reg     <= 1'b0;
            sat_reg     <= 1'b0;
            matched_reg <= 1'b0;
            lim_reg     <= 1'b0;
            wl_reg      <= 8'd0;
        end
        else if (step)
        begin
            phase_reg   <= phase_next;
            base_reg    <= base_next;
            acc_reg     <= acc_next;
            neg_reg     <= neg_next;
            sat_reg     <= sat_next;
            matched_reg <= matched_next;
            lim_reg     <= lim_next;
            wl_reg      <= wl_next;
        end
    end

endmodule

`default_nettype wire

>>> dv/tb_ascii_integer_field_parser_top.sv
// Testbench for the ASCII integer field parser: predicted fields vs. result beats.
`timescale 1ns / 100ps

module tb_ascii_integer_field_parser_top;

    localparam int IDLE_LIMIT = 1000;
    localparam int BEATS_PER_PHASE = 92;
    localparam int NUM_PHASES = 12;

    // kinds past hex behave as signed decimal
    localparam logic [2:0] KIND_RSVD5 = 3'd5;
    localparam logic [2:0] KIND_RSVD6 = 3'd6;
    localparam logic [2:0] KIND_RSVD7 = 3'd7;

    typedef struct packed {
        logic [7:0] ch;
        logic       nf;
        logic       eot;
    } text_beat_t;

    typedef struct packed {
        logic [63:0] value;
        logic        found;
        logic        not_consumed;
    } field_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  character = 8'd0;
    logic        new_field = 1'b0;
    logic        end_of_text = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [63:0] value;
    logic        found;
    logic        byte_not_consumed;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = 4'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    ascii_integer_field_parser_top i_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_stall          (in_stall),
        .character         (character),
        .new_field         (new_field),
        .end_of_text       (end_of_text),
        .out_valid         (out_valid),
        .out_stall         (out_stall),
        .value             (value),
        .found             (found),
        .byte_not_consumed (byte_not_consumed),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    always #5 clk = ~clk;

    text_beat_t    text_beats[$];
    field_result_t expected_fields[$];
    int            mismatches = 0;
    int            beats_queued = 0;
    int            idle_cycles = 0;
    logic          field_head = 1'b0;

    // register shadows
    logic [2:0] cfg_kind = afp_pkg::KIND_SDEC;
    logic [7:0] cfg_width = 8'd0;
    logic [1:0] cfg_size = afp_pkg::SIZE_32;

    // parser state as predicted
    afp_pkg::phase_t fp_phase;
    afp_pkg::base_t  fp_base;
    logic [63:0]     fp_acc;
    logic            fp_neg;
    logic [8:0]      fp_left;
    logic            fp_limited;
    logic            fp_sat;
    logic            fp_matched;

    logic [2:0] phase_kind [NUM_PHASES] = '{afp_pkg::KIND_SDEC, afp_pkg::KIND_AUTO,
                                            afp_pkg::KIND_UDEC, afp_pkg::KIND_OCT,
                                            afp_pkg::KIND_HEX, KIND_RSVD5,
                                            afp_pkg::KIND_AUTO, afp_pkg::KIND_HEX,
                                            KIND_RSVD6, KIND_RSVD7,
                                            afp_pkg::KIND_OCT, afp_pkg::KIND_AUTO};
    logic [7:0] phase_width [NUM_PHASES] = '{8'd0, 8'd255, 8'd1, 8'd2, 8'd0, 8'd5,
                                             8'd2, 8'd3, 8'd0, 8'd24, 8'd7, 8'd0};
    logic [1:0] phase_size [NUM_PHASES] = '{afp_pkg::SIZE_64, afp_pkg::SIZE_32,
                                            afp_pkg::SIZE_16, afp_pkg::SIZE_8,
                                            afp_pkg::SIZE_64, afp_pkg::SIZE_8,
                                            afp_pkg::SIZE_16, afp_pkg::SIZE_32,
                                            afp_pkg::SIZE_64, afp_pkg::SIZE_32,
                                            afp_pkg::SIZE_8, afp_pkg::SIZE_16};

    function automatic void parser_reset();
        fp_phase = afp_pkg::PH_START;
        fp_base = afp_pkg::BASE_DEC;
        fp_acc = '0;
        fp_neg = 1'b0;
        fp_left = '0;
        fp_limited = 1'b0;
        fp_sat = 1'b0;
        fp_matched = 1'b0;
    endfunction

    function automatic logic [2:0] live_kind();
        return (cfg_kind > afp_pkg::KIND_HEX) ? afp_pkg::KIND_SDEC : cfg_kind;
    endfunction

    function automatic int char_digit(input logic [7:0] c, input afp_pkg::base_t b);
        int lim;
        lim = (b == afp_pkg::BASE_OCT) ? 8 : ((b == afp_pkg::BASE_HEX) ? 16 : 10);
        if (c >= afp_pkg::CH_0 && c <= afp_pkg::CH_9)
            return (c - afp_pkg::CH_0 < lim) ? int'(c - afp_pkg::CH_0) : -1;
        if (b == afp_pkg::BASE_HEX && c >= afp_pkg::CH_A_LO && c <= afp_pkg::CH_F_LO)
            return int'(c - afp_pkg::CH_A_LO) + 10;
        if (b == afp_pkg::BASE_HEX && c >= afp_pkg::CH_A_UP && c <= afp_pkg::CH_F_UP)
            return int'(c - afp_pkg::CH_A_UP) + 10;
        return -1;
    endfunction

    function automatic void close_field(input logic unconsumed);
        field_result_t r;
        logic [63:0]   v;
        v = '0;
        if (fp_matched) begin
            if (fp_sat) begin
                if (live_kind() <= afp_pkg::KIND_AUTO)
                    v = fp_neg ? afp_pkg::SMIN_PAT : afp_pkg::SMAX;
                else
                    v = fp_neg ? 64'd0 : afp_pkg::UMAX;
            end
            else begin
                v = fp_neg ? -fp_acc : fp_acc;
            end
            case (cfg_size)
                afp_pkg::SIZE_8:  v = {56'd0, v[7:0]};
                afp_pkg::SIZE_16: v = {48'd0, v[15:0]};
                afp_pkg::SIZE_32: v = {32'd0, v[31:0]};
                default: ;
            endcase
        end
        r.value = v;
        r.found = fp_matched;
        r.not_consumed = unconsumed;
        expected_fields.push_back(r);
        fp_phase = afp_pkg::PH_DONE;
    endfunction

    function automatic void spend_width();
        if (fp_limited) begin
            if (fp_left > 0)
                fp_left = fp_left - 1'b1;
            if (fp_left == 0)
                close_field(1'b0);
        end
    endfunction

    // advance the predicted parser by one accepted text beat
    function automatic void parse_beat(input logic [7:0] c, input logic nf, input logic eot);
        logic [2:0]  k;
        int          d;
        logic [63:0] radix;
        logic [63:0] ceiling;
        k = live_kind();
        if (nf)
            fp_phase = afp_pkg::PH_START;
        if (fp_phase == afp_pkg::PH_DONE)
            return;
        if (fp_phase == afp_pkg::PH_START) begin
            fp_acc = '0;
            fp_neg = 1'b0;
            fp_sat = 1'b0;
            fp_matched = 1'b0;
            fp_base = afp_pkg::BASE_DEC;
            fp_limited = (cfg_width != 0);
            fp_left = {1'b0, cfg_width};
        end
        if (eot) begin
            close_field(1'b0);
            return;
        end
        if (fp_phase == afp_pkg::PH_START) begin
            if (c == afp_pkg::CH_PLUS || c == afp_pkg::CH_MINUS) begin
                fp_neg = (c == afp_pkg::CH_MINUS);
                fp_phase = afp_pkg::PH_SIGNED;
                spend_width();
                return;
            end
            fp_phase = afp_pkg::PH_SIGNED;
        end
        if (fp_phase == afp_pkg::PH_SIGNED) begin
            // a leading zero opens a prefix; auto base needs room for a second byte
            if (c == afp_pkg::CH_0 && (k == afp_pkg::KIND_HEX ||
                    (k == afp_pkg::KIND_AUTO && (!fp_limited || fp_left > 1)))) begin
                fp_matched = 1'b1;
                fp_base = (k == afp_pkg::KIND_HEX) ? afp_pkg::BASE_HEX : afp_pkg::BASE_OCT;
                fp_phase = afp_pkg::PH_ZERO;
                spend_width();
                return;
            end
            fp_base = (k == afp_pkg::KIND_OCT) ? afp_pkg::BASE_OCT
                    : ((k == afp_pkg::KIND_HEX) ? afp_pkg::BASE_HEX : afp_pkg::BASE_DEC);
            fp_phase = afp_pkg::PH_DIGITS;
        end
        else if (fp_phase == afp_pkg::PH_ZERO) begin
            if (c == afp_pkg::CH_X_LO || c == afp_pkg::CH_X_UP) begin
                fp_base = afp_pkg::BASE_HEX;
                fp_phase = afp_pkg::PH_DIGITS;
                spend_width();
                return;
            end
            fp_phase = afp_pkg::PH_DIGITS;
        end
        d = char_digit(c, fp_base);
        if (d < 0) begin
            close_field(1'b1);
            return;
        end
        fp_matched = 1'b1;
        if (!fp_sat) begin
            radix = (fp_base == afp_pkg::BASE_HEX) ? 64'd16
                  : ((fp_base == afp_pkg::BASE_OCT) ? 64'd8 : 64'd10);
            ceiling = (k <= afp_pkg::KIND_AUTO) ? afp_pkg::SMAX : afp_pkg::UMAX;
            if (fp_acc > (ceiling - 64'(d)) / radix) begin
                fp_sat = 1'b1;
                fp_acc = ceiling;
            end
            else begin
                fp_acc = fp_acc * radix + 64'(d);
            end
        end
        spend_width();
    endfunction

    // ---------------- driver ----------------
    int   in_gap = 0;
    logic in_calm = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        text_beat_t b;
        if (!rst_n) begin
            in_valid <= 1'b0;
            character <= 8'd0;
            new_field <= 1'b0;
            end_of_text <= 1'b0;
            in_gap = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                parse_beat(character, new_field, end_of_text);
                in_gap = in_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 47) == 0)
                    in_calm = !in_calm;
            end
            if (!in_valid || !in_stall) begin
                if (in_gap > 0) begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (text_beats.size() > 0) begin
                    b = text_beats.pop_front();
                    in_valid <= 1'b1;
                    character <= b.ch;
                    new_field <= b.nf;
                    end_of_text <= b.eot;
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- monitor ----------------
    int   out_hold = 0;
    logic out_calm = 1'b0;

    always @(posedge clk or negedge rst_n) begin
        field_result_t e;
        if (!rst_n) begin
            out_stall <= 1'b0;
            out_hold = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_fields.size() == 0) begin
                    $error("result beat with nothing expected: value %h found %b", value, found);
                    mismatches++;
                end
                else begin
                    e = expected_fields.pop_front();
                    if (value !== e.value) begin
                        $error("value: expected %h, actual %h", e.value, value);
                        mismatches++;
                    end
                    if (found !== e.found) begin
                        $error("found: expected %b, actual %b", e.found, found);
                        mismatches++;
                    end
                    if (byte_not_consumed !== e.not_consumed) begin
                        $error("byte_not_consumed: expected %b, actual %b",
                               e.not_consumed, byte_not_consumed);
                        mismatches++;
                    end
                end
                out_hold = out_calm ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 31) == 0)
                    out_calm = !out_calm;
            end
            else if (out_hold > 0) begin
                out_hold = out_hold - 1;
            end
            out_stall <= (out_hold != 0);
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ---------------- stimulus ----------------
    task automatic reg_write(input afp_pkg::reg_index_t idx, input logic [31:0] data);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [2:0] k, input logic [7:0] w, input logic [1:0] s);
        logic [31:0] junk;
        junk = $urandom;
        reg_write(afp_pkg::REG_KIND, {junk[31:3], k});
        reg_write(afp_pkg::REG_WIDTH, {junk[31:8], w});
        reg_write(afp_pkg::REG_SIZE, {junk[31:2], s});
        cfg_kind = k;
        cfg_width = w;
        cfg_size = s;
        @(negedge clk);
    endtask

    // wait until the block is idle: nothing queued, in flight or owed
    task automatic drain();
        do @(negedge clk);
        while (text_beats.size() != 0 || in_valid || expected_fields.size() != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic text_beat(input logic [7:0] c, input logic eot);
        text_beat_t b;
        b.ch = c;
        b.nf = field_head;
        b.eot = eot;
        text_beats.push_back(b);
        field_head = 1'b0;
        beats_queued++;
    endtask

    task automatic push_field(input string s);
        field_head = 1'b1;
        for (int i = 0; i < s.len(); i++)
            text_beat(s[i], 1'b0);
    endtask

    task automatic gen_field(input logic [2:0] k);
        string glyphs;
        int    span;
        int    sel;
        int    ndig;
        text_beat_t b;
        glyphs = "0123456789abcdefABCDEF";
        span = (k == afp_pkg::KIND_OCT) ? 8
             : ((k == afp_pkg::KIND_HEX || k == afp_pkg::KIND_AUTO) ? 22 : 10);
        field_head = 1'b1;
        sel = $urandom_range(0, 9);
        if (sel < 2)
            text_beat(afp_pkg::CH_MINUS, 1'b0);
        else if (sel == 2)
            text_beat(afp_pkg::CH_PLUS, 1'b0);
        if ($urandom_range(0, 3) == 0) begin
            text_beat(afp_pkg::CH_0, 1'b0);
            if ((k == afp_pkg::KIND_AUTO || k == afp_pkg::KIND_HEX) &&
                $urandom_range(0, 2) != 0)
                text_beat($urandom_range(0, 1) ? afp_pkg::CH_X_LO : afp_pkg::CH_X_UP, 1'b0);
        end
        // long runs push past the 64-bit ceiling
        ndig = ($urandom_range(0, 4) == 0) ? $urandom_range(16, 26) : $urandom_range(0, 7);
        repeat (ndig) begin
            if ($urandom_range(0, 15) == 0)
                text_beat(glyphs[$urandom_range(0, 21)], 1'b0);
            else
                text_beat(glyphs[$urandom_range(0, span - 1)], 1'b0);
        end
        sel = $urandom_range(0, 3);
        case (sel)
            0: text_beat(8'($urandom), 1'b1);
            1: text_beat(8'($urandom), 1'b0);
            2: text_beat(8'h20, 1'b0);
            default: if (field_head) text_beat(8'($urandom), 1'b0);
        endcase
        // stray bytes after a closed field, no new_field
        if (sel < 3 && $urandom_range(0, 3) == 0) begin
            b.ch = 8'($urandom);
            b.nf = 1'b0;
            b.eot = ($urandom_range(0, 1) == 1);
            text_beats.push_back(b);
        end
    endtask

    task automatic noise_burst();
        text_beat_t b;
        repeat ($urandom_range(1, 4)) begin
            b.ch = 8'($urandom);
            b.nf = ($urandom_range(0, 3) == 0);
            b.eot = ($urandom_range(0, 7) == 0);
            text_beats.push_back(b);
            beats_queued++;
        end
    endtask

    initial begin
        int start;
        parser_reset();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset config: signed decimal, unlimited, 32-bit
        push_field("-4");
        text_beat(8'h00, 1'b1);
        push_field("+,");               // sign alone fails
        field_head = 1'b1;
        text_beat(8'hff, 1'b1);         // end of text before any byte
        text_beat(afp_pkg::CH_7, 1'b0); // field closed: ignored
        field_head = 1'b1;
        text_beat(8'hff, 1'b0);         // non-digit first byte
        drain();

        set_config(afp_pkg::KIND_UDEC, 8'd0, afp_pkg::SIZE_32);
        push_field("-1");               // negative unsigned wraps
        text_beat(8'h00, 1'b1);
        drain();
        set_config(afp_pkg::KIND_OCT, 8'd0, afp_pkg::SIZE_16);
        push_field("78");
        drain();
        set_config(afp_pkg::KIND_AUTO, 8'd0, afp_pkg::SIZE_64);
        push_field("0xg");              // bare prefix
        drain();
        set_config(afp_pkg::KIND_AUTO, 8'd1, afp_pkg::SIZE_8);
        push_field("0");                // no room for octal: decimal zero
        drain();
        set_config(afp_pkg::KIND_HEX, 8'd0, afp_pkg::SIZE_64);
        push_field("FFFFFFFFFFFFFFFFF");  // saturates
        text_beat(8'h00, 1'b1);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            set_config(phase_kind[p], phase_width[p], phase_size[p]);
            start = beats_queued;
            while (beats_queued - start < BEATS_PER_PHASE) begin
                if ($urandom_range(0, 9) == 0)
                    noise_burst();
                else
                    gen_field(phase_kind[p]);
            end
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
